@@ rtl/core/pps_pkg.sv @@
// ---------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the parallel port to SPI bridge.
// ---------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    // Event codes carried in the kind field
    typedef enum logic [2:0] {
        EV_REQ    = 3'd0,
        EV_STROBE = 3'd1,
        EV_REL    = 3'd2,
        EV_CARD   = 3'd3,
        EV_SPI    = 3'd4
    } event_t;

    // Command phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LONG2   = 3'd1,
        PH_READ    = 3'd2,
        PH_WSTROBE = 3'd3,
        PH_WSPI    = 3'd4,
        PH_CARD    = 3'd5,
        PH_WAITREL = 3'd6
    } phase_t;

    // Sub-commands of the 0xC0 group (command bits 5..1)
    localparam logic [4:0] SUB_SELECT = 5'd0;
    localparam logic [4:0] SUB_CARD   = 5'd1;
    localparam logic [4:0] SUB_SPEED  = 5'd2;

    localparam int CountW = 13;

    // SPI line idles high; reads shift out all ones
    localparam logic [7:0] SPI_IDLE_BYTE = 8'hff;

    // One input word
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] port_data;
        logic       card_detect_level;
        logic [7:0] spi_rx_byte;
    } item_t;

    // One result word
    typedef struct packed {
        logic [7:0] port_out;
        logic       port_drive;
        logic       active_n;
        logic       irq_asserted;
        logic       select_n;
        logic       spi_send;
        logic [7:0] spi_tx_byte;
        logic       speed_fast;
        logic       transfer_done;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/parallel_port_to_spi_bridge.sv @@
// ---------------------------------------------------------------------------
// parallel_port_to_spi_bridge
// Parallel port target bridged to an SPI master, one event word at a time.
// ---------------------------------------------------------------------------
// Each event word (request start, strobe toggle, request release, card
// detect sample, SPI byte received) yields exactly one result word with the
// port, acknowledge, interrupt, select and speed levels after the event and
// any SPI exchange it starts. The block takes one word per clock while not
// stalled; a word passes an input register and the command state machine and
// is captured in the result register. The result register stalls
// only when a result is waiting and out_stall is high; the input register
// stalls only when, in addition, it already holds a word.
// ---------------------------------------------------------------------------
`default_nettype none

module parallel_port_to_spi_bridge
    import pps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] kind,
    input  wire logic [7:0] port_data,
    input  wire logic       card_detect_level,
    input  wire logic [7:0] spi_rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      port_out,
    output logic            port_drive,
    output logic            active_n,
    output logic            irq_asserted,
    output logic            select_n,
    output logic            spi_send,
    output logic [7:0]      spi_tx_byte,
    output logic            speed_fast,
    output logic            transfer_done
);

    item_t   in_item;
    item_t   hold_item;
    logic    hold_valid;
    logic    advance;
    result_t result;
    result_t out_result;

    assign in_item.kind              = kind;
    assign in_item.port_data         = port_data;
    assign in_item.card_detect_level = card_detect_level;
    assign in_item.spi_rx_byte       = spi_rx_byte;

    pps_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item       (in_item),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    pps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (hold_valid && advance),
        .item   (hold_item),
        .result (result)
    );

    pps_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_valid (hold_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign port_out      = out_result.port_out;
    assign port_drive    = out_result.port_drive;
    assign active_n      = out_result.active_n;
    assign irq_asserted  = out_result.irq_asserted;
    assign select_n      = out_result.select_n;
    assign spi_send      = out_result.spi_send;
    assign spi_tx_byte   = out_result.spi_tx_byte;
    assign speed_fast    = out_result.speed_fast;
    assign transfer_done = out_result.transfer_done;

endmodule

`default_nettype wire

@@ rtl/core/pps_in_stage.sv @@
// ---------------------------------------------------------------------------
// pps_in_stage
// Input register: holds one event word until the update stage takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module pps_in_stage
    import pps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire item_t      item,
    input  wire logic       advance,
    output logic            hold_valid,
    output item_t           hold_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // Refill when empty or when the held word moves on
    assign load       = !valid_reg || advance;
    assign in_stall   = !load;
    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

`default_nettype wire

@@ rtl/core/pps_ctrl.sv @@
// ---------------------------------------------------------------------------
// pps_ctrl
// Command state machine and bridge state; one event word applied per fire.
// ---------------------------------------------------------------------------
`default_nettype none

module pps_ctrl
    import pps_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire item_t   item,
    output result_t      result
);

    phase_t              phase_reg, phase_next;
    logic [CountW-1:0]   bytes_left_reg, bytes_left_next;
    logic                read_dir_reg, read_dir_next;
    logic [7:0]          rx_hold_reg, rx_hold_next;
    logic                rx_ready_reg, rx_ready_next;
    logic                pending_reg, pending_next;
    logic                select_reg, select_next;
    logic                fast_reg, fast_next;
    logic                irq_reg, irq_next;
    logic                last_card_reg, last_card_next;
    logic                card_seen_reg, card_seen_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_en_reg, out_en_next;
    logic                ack_reg, ack_next;
    logic                send;
    logic [7:0]          tx_byte;

    logic [7:0]          cmd;
    logic                is_xfer_cmd;
    logic [4:0]          sub;
    logic                last_byte;
    logic [CountW-1:0]   bytes_dec;
    event_t              ev;

    assign cmd         = item.port_data;
    assign is_xfer_cmd = (cmd[7:6] != 2'b11);
    assign sub         = cmd[5:1];
    assign last_byte   = (bytes_left_reg == '0);
    assign bytes_dec   = bytes_left_reg - CountW'(1);
    assign ev          = event_t'(item.kind);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (ev)
            EV_REL:
            begin
                phase_next = PH_IDLE;
            end
            EV_REQ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (is_xfer_cmd)
                    begin
                        if (cmd[7])
                            phase_next = PH_LONG2;
                        else
                            phase_next = cmd[6] ? PH_READ : PH_WSTROBE;
                    end
                    else if (sub == SUB_CARD)
                    begin
                        phase_next = PH_CARD;
                    end
                    else
                    begin
                        phase_next = PH_WAITREL;
                    end
                end
            end
            EV_STROBE:
            begin
                unique case (phase_reg)
                    PH_LONG2:   phase_next = item.port_data[7] ? PH_READ : PH_WSTROBE;
                    PH_READ:
                    begin
                        if (rx_ready_reg && last_byte)
                            phase_next = PH_WAITREL;
                    end
                    PH_WSTROBE: phase_next = PH_WSPI;
                    PH_CARD:    phase_next = PH_WAITREL;
                    default:    phase_next = phase_reg;
                endcase
            end
            EV_SPI:
            begin
                if (phase_reg == PH_READ)
                begin
                    if (pending_reg && last_byte)
                        phase_next = PH_WAITREL;
                end
                else if (phase_reg == PH_WSPI)
                begin
                    if (last_byte)
                        phase_next = PH_WAITREL;
                    else if (!pending_reg)
                        phase_next = PH_WSTROBE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Data registers and SPI request
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        read_dir_next   = read_dir_reg;
        rx_hold_next    = rx_hold_reg;
        rx_ready_next   = rx_ready_reg;
        pending_next    = pending_reg;
        select_next     = select_reg;
        fast_next       = fast_reg;
        irq_next        = irq_reg;
        last_card_next  = last_card_reg;
        card_seen_next  = card_seen_reg;
        out_byte_next   = out_byte_reg;
        out_en_next     = out_en_reg;
        ack_next        = ack_reg;
        send            = 1'b0;
        tx_byte         = SPI_IDLE_BYTE;

        unique case (ev)
            EV_CARD:
            begin
                if (!card_seen_reg)
                begin
                    card_seen_next = 1'b1;
                    last_card_next = item.card_detect_level;
                end
                else if (phase_reg == PH_IDLE && item.card_detect_level != last_card_reg)
                begin
                    irq_next       = 1'b1;
                    last_card_next = item.card_detect_level;
                end
            end
            EV_REL:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    out_en_next   = 1'b0;
                    out_byte_next = 8'h00;
                    ack_next      = 1'b1;
                    pending_next  = 1'b0;
                    rx_ready_next = 1'b0;
                end
            end
            EV_REQ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (is_xfer_cmd)
                    begin
                        ack_next = 1'b0;
                        if (!cmd[7])
                        begin
                            read_dir_next   = cmd[6];
                            bytes_left_next = {7'd0, cmd[5:0]};
                            pending_next    = 1'b0;
                            rx_ready_next   = 1'b0;
                            send            = cmd[6];
                        end
                        else
                        begin
                            bytes_left_next = {cmd[5:0], 7'd0};
                        end
                    end
                    else
                    begin
                        unique case (sub)
                            SUB_SELECT:
                            begin
                                select_next = !cmd[0];
                                ack_next    = 1'b0;
                            end
                            SUB_CARD:
                            begin
                                irq_next = 1'b0;
                                ack_next = 1'b0;
                            end
                            SUB_SPEED:
                            begin
                                fast_next = cmd[0];
                                ack_next  = 1'b0;
                            end
                            default:
                            begin
                                ack_next = ack_reg;
                            end
                        endcase
                    end
                end
            end
            EV_STROBE:
            begin
                unique case (phase_reg)
                    PH_LONG2:
                    begin
                        read_dir_next   = item.port_data[7];
                        bytes_left_next = bytes_left_reg | {6'd0, item.port_data[6:0]};
                        pending_next    = 1'b0;
                        rx_ready_next   = 1'b0;
                        send            = item.port_data[7];
                    end
                    PH_READ:
                    begin
                        if (rx_ready_reg)
                        begin
                            out_byte_next = rx_hold_reg;
                            out_en_next   = 1'b1;
                            rx_ready_next = 1'b0;
                            pending_next  = 1'b0;
                            if (!last_byte)
                            begin
                                bytes_left_next = bytes_dec;
                                send            = 1'b1;
                            end
                        end
                        else
                        begin
                            pending_next = !pending_reg;
                        end
                    end
                    PH_WSTROBE:
                    begin
                        send    = 1'b1;
                        tx_byte = item.port_data;
                    end
                    PH_WSPI:
                    begin
                        pending_next = !pending_reg;
                        rx_hold_next = item.port_data;
                    end
                    PH_CARD:
                    begin
                        out_byte_next = {7'd0, !item.card_detect_level};
                        out_en_next   = 1'b1;
                    end
                    default:
                    begin
                        send = 1'b0;
                    end
                endcase
            end
            EV_SPI:
            begin
                if (phase_reg == PH_READ)
                begin
                    if (pending_reg)
                    begin
                        out_byte_next = item.spi_rx_byte;
                        out_en_next   = 1'b1;
                        rx_ready_next = 1'b0;
                        pending_next  = 1'b0;
                        if (!last_byte)
                        begin
                            bytes_left_next = bytes_dec;
                            send            = 1'b1;
                        end
                    end
                    else
                    begin
                        rx_hold_next  = item.spi_rx_byte;
                        rx_ready_next = 1'b1;
                    end
                end
                else if (phase_reg == PH_WSPI)
                begin
                    if (last_byte)
                    begin
                        pending_next = 1'b0;
                    end
                    else
                    begin
                        bytes_left_next = bytes_dec;
                        if (pending_reg)
                        begin
                            pending_next = 1'b0;
                            send         = 1'b1;
                            tx_byte      = rx_hold_reg;
                        end
                    end
                end
            end
            default:
            begin
                send = 1'b0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= '0;
            read_dir_reg   <= 1'b0;
            rx_hold_reg    <= 8'h00;
            rx_ready_reg   <= 1'b0;
            pending_reg    <= 1'b0;
            select_reg     <= 1'b1;
            fast_reg       <= 1'b0;
            irq_reg        <= 1'b0;
            last_card_reg  <= 1'b0;
            card_seen_reg  <= 1'b0;
            out_byte_reg   <= 8'h00;
            out_en_reg     <= 1'b0;
            ack_reg        <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            read_dir_reg   <= read_dir_next;
            rx_hold_reg    <= rx_hold_next;
            rx_ready_reg   <= rx_ready_next;
            pending_reg    <= pending_next;
            select_reg     <= select_next;
            fast_reg       <= fast_next;
            irq_reg        <= irq_next;
            last_card_reg  <= last_card_next;
            card_seen_reg  <= card_seen_next;
            out_byte_reg   <= out_byte_next;
            out_en_reg     <= out_en_next;
            ack_reg        <= ack_next;
        end
    end

    // Result word: state after the event, plus per-event strobes
    always_comb
    begin
        result.port_out      = out_byte_next;
        result.port_drive    = out_en_next;
        result.active_n      = ack_next;
        result.irq_asserted  = irq_next;
        result.select_n      = select_next;
        result.spi_send      = send;
        result.spi_tx_byte   = tx_byte;
        result.speed_fast    = fast_next;
        result.transfer_done = (phase_next == PH_WAITREL) && (phase_reg != PH_WAITREL);
    end

endmodule

`default_nettype wire

@@ rtl/core/pps_out_stage.sv @@
// ---------------------------------------------------------------------------
// pps_out_stage
// Result register; frees the update stage whenever it is empty or drained.
// ---------------------------------------------------------------------------
`default_nettype none

module pps_out_stage
    import pps_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    hold_valid,
    input  wire result_t result,
    output logic         advance,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? hold_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (advance && hold_valid)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

@@ rtl/core/pps_checker.sv @@
// ---------------------------------------------------------------------------
// pps_checker
// Port-level checks for the parallel port to SPI bridge.
// ---------------------------------------------------------------------------
`default_nettype none

module pps_checker
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] port_out,
    input  wire logic       port_drive,
    input  wire logic       active_n,
    input  wire logic       spi_send,
    input  wire logic [7:0] spi_tx_byte,
    input  wire logic       transfer_done
);

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(port_out) && $stable(spi_tx_byte))
        else $error("result changed while stalled");

    // SPI line idles high when no exchange starts
    a_idle_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !spi_send |-> spi_tx_byte == 8'hff)
        else $error("tx byte not idle without send");

    // Completion never starts another exchange
    a_done_nosend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && transfer_done |-> !spi_send)
        else $error("send on completing word");

    // Exchanges only while a command is served
    a_send_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && spi_send |-> !active_n)
        else $error("send with acknowledge inactive");

    // Undriven port reads zero
    a_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !port_drive |-> port_out == 8'h00)
        else $error("port byte set while not driving");

endmodule

bind parallel_port_to_spi_bridge pps_checker u_pps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .port_out      (port_out),
    .port_drive    (port_drive),
    .active_n      (active_n),
    .spi_send      (spi_send),
    .spi_tx_byte   (spi_tx_byte),
    .transfer_done (transfer_done)
);

`default_nettype wire

@@ verif/parallel_port_to_spi_bridge_test.sv @@
// ---------------------------------------------------------------------------
// parallel_port_to_spi_bridge_test
// Self-checking bench for the parallel port to SPI bridge.
// ---------------------------------------------------------------------------
// Event words go in through the valid/stall input channel. Every accepted
// word runs through a local model of the bridge, and the line levels it
// predicts are queued. Each result word is checked against the oldest queued
// entry. A short table of directed words comes first, then random command
// transfers with random content, aborts and stray events. Both channels idle
// in random bursts.
// ---------------------------------------------------------------------------
`default_nettype none

module parallel_port_to_spi_bridge_test;
    import pps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClkPeriod  = 4;
    localparam int ItemTarget = 1600;
    localparam int CalmFrom   = 1350;
    localparam int DrainWait  = 8;
    localparam int CycleLimit = 400000;

    // Command byte encodings
    localparam logic [7:0] SHORT_WRITE = 8'h00;
    localparam logic [7:0] SHORT_READ  = 8'h40;
    localparam logic [7:0] LONG_CMD    = 8'h80;
    localparam logic [7:0] CMD_GROUP   = 8'hc0;
    localparam logic [7:0] CMD_CARD    = CMD_GROUP | {2'b00, SUB_CARD, 1'b1};
    localparam logic [7:0] CMD_SEL_ON  = CMD_GROUP | {2'b00, SUB_SELECT, 1'b1};
    localparam logic [7:0] CMD_FAST    = CMD_GROUP | {2'b00, SUB_SPEED, 1'b1};
    localparam logic [7:0] CMD_UNKNOWN = 8'hff;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] kind = EV_REL;
    logic [7:0] port_data = 8'h00;
    logic       card_detect_level = 1'b0;
    logic [7:0] spi_rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] port_out;
    logic       port_drive;
    logic       active_n;
    logic       irq_asserted;
    logic       select_n;
    logic       spi_send;
    logic [7:0] spi_tx_byte;
    logic       speed_fast;
    logic       transfer_done;

    parallel_port_to_spi_bridge dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .kind              (kind),
        .port_data         (port_data),
        .card_detect_level (card_detect_level),
        .spi_rx_byte       (spi_rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .port_out          (port_out),
        .port_drive        (port_drive),
        .active_n          (active_n),
        .irq_asserted      (irq_asserted),
        .select_n          (select_n),
        .spi_send          (spi_send),
        .spi_tx_byte       (spi_tx_byte),
        .speed_fast        (speed_fast),
        .transfer_done     (transfer_done)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    // Model state of the bridge
    phase_t      ph = PH_IDLE;
    logic [12:0] count_left = '0;
    logic        is_read = 1'b0;
    logic [7:0]  hold_byte = 8'h00;
    logic        hold_valid = 1'b0;
    logic        strobe_seen = 1'b0;
    logic        sel_level = 1'b1;
    logic        fast_clk = 1'b0;
    logic        irq_level = 1'b0;
    logic        card_level = 1'b0;
    logic        card_known = 1'b0;
    logic [7:0]  drive_byte = 8'h00;
    logic        drive_en = 1'b0;
    logic        ack_n = 1'b1;

    result_t due_levels [$];
    int      fault_count = 0;
    int      levels_seen = 0;
    int      words_taken = 0;
    int      cycle_count = 0;
    bit      word_taken = 1'b0;
    bit      row_fixed = 1'b0;
    result_t row_want = '0;
    int      idle_odds = 20;
    int      stall_odds = 20;
    bit      calm = 1'b0;
    int      stall_left = 0;

    // Directed table: typed-in levels only where they are plain to read
    typedef struct {
        item_t   word;
        bit      fixed;
        result_t want;
    } plan_row_t;

    plan_row_t opening_plan [30] = '{
        // first card sample is only recorded
        '{'{EV_CARD, 8'h00, 1'b1, 8'h00}, 1'b1,
          '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, SPI_IDLE_BYTE, 1'b0, 1'b0}},
        // level change while idle raises the interrupt
        '{'{EV_CARD, 8'hff, 1'b0, 8'hff}, 1'b1,
          '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, SPI_IDLE_BYTE, 1'b0, 1'b0}},
        // strobe and release while idle do nothing
        '{'{EV_STROBE, 8'hff, 1'b1, 8'h00}, 1'b1,
          '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, SPI_IDLE_BYTE, 1'b0, 1'b0}},
        '{'{EV_REL, 8'h00, 1'b0, 8'hff}, 1'b1,
          '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, SPI_IDLE_BYTE, 1'b0, 1'b0}},
        // card query: interrupt released, presence on next strobe
        '{'{EV_REQ, CMD_CARD, 1'b1, 8'h00}, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, SPI_IDLE_BYTE, 1'b0, 1'b0}},
        '{'{EV_STROBE, 8'h00, 1'b0, 8'h00}, 1'b1,
          '{8'h01, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, SPI_IDLE_BYTE, 1'b0, 1'b1}},
        // request start while busy is ignored
        '{'{EV_REQ, SHORT_READ, 1'b0, 8'h00}, 1'b1,
          '{8'h01, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, SPI_IDLE_BYTE, 1'b0, 1'b0}},
        '{'{EV_REL, 8'h00, 1'b0, 8'h00}, 1'b1,
          '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, SPI_IDLE_BYTE, 1'b0, 1'b0}},
        // chip select on
        '{'{EV_REQ, CMD_SEL_ON, 1'b0, 8'h00}, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SPI_IDLE_BYTE, 1'b0, 1'b1}},
        '{'{EV_REL, 8'h00, 1'b0, 8'h00}, 1'b1,
          '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, SPI_IDLE_BYTE, 1'b0, 1'b0}},
        // fast clock
        '{'{EV_REQ, CMD_FAST, 1'b0, 8'h00}, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, SPI_IDLE_BYTE, 1'b1, 1'b1}},
        '{'{EV_REL, 8'h00, 1'b0, 8'h00}, 1'b1,
          '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, SPI_IDLE_BYTE, 1'b1, 1'b0}},
        // unknown sub-command completes with ack left high
        '{'{EV_REQ, CMD_UNKNOWN, 1'b0, 8'h00}, 1'b1,
          '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, SPI_IDLE_BYTE, 1'b1, 1'b1}},
        '{'{EV_REL, 8'h00, 1'b0, 8'h00}, 1'b1,
          '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, SPI_IDLE_BYTE, 1'b1, 1'b0}},
        // one-byte read, strobe ahead of the SPI byte, card sample while busy
        '{'{EV_REQ, SHORT_READ, 1'b0, 8'h00}, 1'b0, '0},
        '{'{EV_STROBE, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{EV_CARD, 8'h00, 1'b1, 8'h00}, 1'b0, '0},
        '{'{EV_SPI, 8'h00, 1'b0, 8'ha5}, 1'b0, '0},
        '{'{EV_REL, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        // two-byte write, second strobe ahead of the first SPI byte
        '{'{EV_REQ, SHORT_WRITE | 8'h01, 1'b0, 8'h00}, 1'b0, '0},
        '{'{EV_STROBE, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{EV_STROBE, 8'hff, 1'b0, 8'h00}, 1'b0, '0},
        '{'{EV_SPI, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{EV_SPI, 8'h00, 1'b0, 8'hff}, 1'b0, '0},
        '{'{EV_REL, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        // longest read, then an undefined kind and an abort
        '{'{EV_REQ, LONG_CMD | 8'h3f, 1'b0, 8'h00}, 1'b0, '0},
        '{'{EV_STROBE, 8'hff, 1'b1, 8'h00}, 1'b0, '0},
        '{'{3'd7, 8'hff, 1'b1, 8'hff}, 1'b0, '0},
        '{'{EV_REL, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        // idle sample differing from the last one seen
        '{'{EV_CARD, 8'h00, 1'b1, 8'h00}, 1'b0, '0}
    };

    // Advance the bridge model by one event word, return the line levels
    function automatic result_t advance_bridge(item_t w);
        result_t    r;
        logic       send;
        logic [7:0] tx;
        logic       done;
        logic       start;
        logic       deliver;
        logic [7:0] rd;
        send = 1'b0;
        tx = SPI_IDLE_BYTE;
        done = 1'b0;
        start = 1'b0;
        deliver = 1'b0;
        rd = 8'h00;
        case (w.kind)
            EV_CARD:
                if (!card_known)
                begin
                    card_known = 1'b1;
                    card_level = w.card_detect_level;
                end
                else if (ph == PH_IDLE && w.card_detect_level != card_level)
                begin
                    irq_level = 1'b1;
                    card_level = w.card_detect_level;
                end
            EV_REL:
                if (ph != PH_IDLE)
                begin
                    ph = PH_IDLE;
                    drive_en = 1'b0;
                    drive_byte = 8'h00;
                    ack_n = 1'b1;
                    strobe_seen = 1'b0;
                    hold_valid = 1'b0;
                end
            EV_REQ:
                if (ph == PH_IDLE)
                begin
                    if (w.port_data[7:6] != 2'b11)
                    begin
                        ack_n = 1'b0;
                        if (!w.port_data[7])
                        begin
                            is_read = w.port_data[6];
                            count_left = {7'd0, w.port_data[5:0]};
                            start = 1'b1;
                        end
                        else
                        begin
                            count_left = {w.port_data[5:0], 7'd0};
                            ph = PH_LONG2;
                        end
                    end
                    else
                    begin
                        case (w.port_data[5:1])
                            SUB_SELECT:
                            begin
                                sel_level = ~w.port_data[0];
                                ack_n = 1'b0;
                                ph = PH_WAITREL;
                                done = 1'b1;
                            end
                            SUB_CARD:
                            begin
                                irq_level = 1'b0;
                                ack_n = 1'b0;
                                ph = PH_CARD;
                            end
                            SUB_SPEED:
                            begin
                                fast_clk = w.port_data[0];
                                ack_n = 1'b0;
                                ph = PH_WAITREL;
                                done = 1'b1;
                            end
                            default:
                            begin
                                ph = PH_WAITREL;
                                done = 1'b1;
                            end
                        endcase
                    end
                end
            EV_STROBE:
                case (ph)
                    PH_LONG2:
                    begin
                        is_read = w.port_data[7];
                        count_left = count_left | {6'd0, w.port_data[6:0]};
                        start = 1'b1;
                    end
                    PH_READ:
                        if (hold_valid)
                        begin
                            deliver = 1'b1;
                            rd = hold_byte;
                        end
                        else
                            strobe_seen = ~strobe_seen;
                    PH_WSTROBE:
                    begin
                        send = 1'b1;
                        tx = w.port_data;
                        ph = PH_WSPI;
                    end
                    PH_WSPI:
                    begin
                        strobe_seen = ~strobe_seen;
                        hold_byte = w.port_data;
                    end
                    PH_CARD:
                    begin
                        drive_byte = w.card_detect_level ? 8'h00 : 8'h01;
                        drive_en = 1'b1;
                        ph = PH_WAITREL;
                        done = 1'b1;
                    end
                    default: ;
                endcase
            EV_SPI:
                if (ph == PH_READ)
                begin
                    if (strobe_seen)
                    begin
                        deliver = 1'b1;
                        rd = w.spi_rx_byte;
                    end
                    else
                    begin
                        hold_byte = w.spi_rx_byte;
                        hold_valid = 1'b1;
                    end
                end
                else if (ph == PH_WSPI)
                begin
                    if (count_left == 0)
                    begin
                        strobe_seen = 1'b0;
                        ph = PH_WAITREL;
                        done = 1'b1;
                    end
                    else
                    begin
                        count_left = count_left - 1'b1;
                        if (strobe_seen)
                        begin
                            strobe_seen = 1'b0;
                            send = 1'b1;
                            tx = hold_byte;
                        end
                        else
                            ph = PH_WSTROBE;
                    end
                end
            default: ;
        endcase

        // transfer set up: reads fire the first exchange at once
        if (start)
        begin
            strobe_seen = 1'b0;
            hold_valid = 1'b0;
            if (is_read)
            begin
                ph = PH_READ;
                send = 1'b1;
                tx = SPI_IDLE_BYTE;
            end
            else
                ph = PH_WSTROBE;
        end

        // read byte handed to the port, next exchange unless last
        if (deliver)
        begin
            drive_byte = rd;
            drive_en = 1'b1;
            hold_valid = 1'b0;
            strobe_seen = 1'b0;
            if (count_left == 0)
            begin
                ph = PH_WAITREL;
                done = 1'b1;
            end
            else
            begin
                count_left = count_left - 1'b1;
                send = 1'b1;
                tx = SPI_IDLE_BYTE;
            end
        end

        r.port_out = drive_byte;
        r.port_drive = drive_en;
        r.active_n = ack_n;
        r.irq_asserted = irq_level;
        r.select_n = sel_level;
        r.spi_send = send;
        r.spi_tx_byte = tx;
        r.speed_fast = fast_clk;
        r.transfer_done = done;
        return r;
    endfunction

    function automatic item_t make_word(logic [2:0] k, logic [7:0] d);
        item_t w;
        w.kind = k;
        w.port_data = d;
        w.card_detect_level = 1'($urandom_range(0, 1));
        w.spi_rx_byte = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // Present one word at the falling edge, hold it until taken
    task automatic send_word(input item_t w);
        if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        kind <= w.kind;
        port_data <= w.port_data;
        card_detect_level <= w.card_detect_level;
        spi_rx_byte <= w.spi_rx_byte;
        in_valid <= 1'b1;
        do
            @(negedge clk);
        while (!word_taken);
    endtask

    // Accept, predict and check at the rising edge
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results due", cycle_count,
                     due_levels.size());
            $display("*** FAILED ***");
            $finish;
        end
        if (rst_n)
        begin
            word_taken = in_valid && !in_stall;
            if (word_taken)
            begin
                want = advance_bridge({kind, port_data, card_detect_level, spi_rx_byte});
                if (row_fixed)
                    want = row_want;
                due_levels.push_back(want);
                if (kind <= EV_SPI)
                    words_taken++;
            end
            if (out_valid && !out_stall)
            begin
                got = {port_out, port_drive, active_n, irq_asserted, select_n,
                       spi_send, spi_tx_byte, speed_fast, transfer_done};
                if (due_levels.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("result %0d arrived with nothing due", levels_seen);
                end
                else
                begin
                    want = due_levels.pop_front();
                    if (got !== want)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                        begin
                            $display("result %0d mismatch", levels_seen);
                            $display("  expected out=%h drv=%b act_n=%b irq=%b sel_n=%b send=%b tx=%h fast=%b done=%b",
                                     want.port_out, want.port_drive, want.active_n,
                                     want.irq_asserted, want.select_n, want.spi_send,
                                     want.spi_tx_byte, want.speed_fast, want.transfer_done);
                            $display("  actual   out=%h drv=%b act_n=%b irq=%b sel_n=%b send=%b tx=%h fast=%b done=%b",
                                     got.port_out, got.port_drive, got.active_n,
                                     got.irq_asserted, got.select_n, got.spi_send,
                                     got.spi_tx_byte, got.speed_fast, got.transfer_done);
                        end
                    end
                end
                levels_seen++;
            end
        end
    end

    // Result-side stall bursts
    always @(negedge clk)
    begin
        if (!rst_n || calm)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds)
                stall_left = $urandom_range(1, 11);
        end
    end

    initial
    begin
        int         pick;
        int         count;
        int         hi;
        int         lo;
        int         planned;
        bit         dir;
        bit         swap;
        bit         drained;
        logic [4:0] sub;
        drained = 1'b0;

        // reset
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed words
        foreach (opening_plan[i])
        begin
            row_fixed = opening_plan[i].fixed;
            row_want = opening_plan[i].want;
            send_word(opening_plan[i].word);
        end
        row_fixed = 1'b0;

        // random transfers
        while (words_taken < ItemTarget)
        begin
            if (words_taken > CalmFrom)
            begin
                idle_odds = 0;
                stall_odds = 0;
                calm = 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                idle_odds = $urandom_range(0, 1) ? 0 : $urandom_range(5, 40);
                stall_odds = $urandom_range(0, 1) ? 0 : $urandom_range(5, 40);
            end

            // hold off once until everything in flight has come back
            if (!drained && words_taken > ItemTarget / 2)
            begin
                in_valid <= 1'b0;
                while (due_levels.size() != 0)
                    @(negedge clk);
                drained = 1'b1;
            end

            if ($urandom_range(0, 3) == 0)
                send_word(make_word(EV_CARD, 8'($urandom_range(0, 255))));

            pick = $urandom_range(0, 9);
            if (pick <= 5)
            begin
                // data transfer, short or long form
                dir = $urandom_range(0, 1);
                if (pick <= 3)
                begin
                    count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, 5);
                    send_word(make_word(EV_REQ,
                        (dir ? SHORT_READ : SHORT_WRITE) | 8'(count)));
                end
                else
                begin
                    hi = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 63) : 0;
                    lo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 6);
                    send_word(make_word(EV_REQ, LONG_CMD | 8'(hi)));
                    send_word(make_word(EV_STROBE, {dir, 7'(lo)}));
                    count = hi * 128 + lo;
                end

                // big counts and some small ones are cut short by the release
                planned = count + 1;
                if (planned > 20 || $urandom_range(0, 9) == 0)
                    planned = $urandom_range(0, (planned > 20) ? 20 : planned);
                for (int b = 0; b < planned; b++)
                begin
                    swap = dir ? $urandom_range(0, 1) : ($urandom_range(0, 9) == 0);
                    if ($urandom_range(0, 29) == 0)
                        send_word(make_word(3'($urandom_range(0, 7)),
                                            8'($urandom_range(0, 255))));
                    if (swap)
                    begin
                        send_word(make_word(EV_SPI, 8'($urandom_range(0, 255))));
                        send_word(make_word(EV_STROBE, 8'($urandom_range(0, 255))));
                    end
                    else
                    begin
                        send_word(make_word(EV_STROBE, 8'($urandom_range(0, 255))));
                        send_word(make_word(EV_SPI, 8'($urandom_range(0, 255))));
                    end
                end
            end
            else if (pick <= 8)
            begin
                // control command, now and then an undefined sub-command
                sub = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 2));
                send_word(make_word(EV_REQ,
                    CMD_GROUP | {2'b00, sub, 1'($urandom_range(0, 1))}));
                if (sub == SUB_CARD || $urandom_range(0, 3) == 0)
                    send_word(make_word(EV_STROBE, 8'($urandom_range(0, 255))));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_word(make_word(3'($urandom_range(0, 7)),
                                        8'($urandom_range(0, 255))));
            end
            send_word(make_word(EV_REL, 8'($urandom_range(0, 255))));
        end

        // drain
        in_valid <= 1'b0;
        while (due_levels.size() != 0)
            @(negedge clk);
        repeat (DrainWait) @(negedge clk);

        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
